### design/bped_pkg.sv
package bped_pkg;

  // Result kinds
  localparam logic [1:0] KIND_ENTRY      = 2'd0;
  localparam logic [1:0] KIND_OK         = 2'd1;
  localparam logic [1:0] KIND_SHORT      = 2'd2;
  localparam logic [1:0] KIND_BAD_HEADER = 2'd3;

  // Packet types
  localparam logic [1:0] TYPE_W24 = 2'd0;
  localparam logic [1:0] TYPE_W47 = 2'd1;
  localparam logic [1:0] TYPE_W64 = 2'd2;

  // Header pairs
  localparam logic [7:0] HDR_W24_FIRST  = 8'h1d;
  localparam logic [7:0] HDR_W24_SECOND = 8'h1a;
  localparam logic [7:0] HDR_W47_FIRST  = 8'h0c;
  localparam logic [7:0] HDR_W47_SECOND = 8'haa;
  localparam logic [7:0] HDR_W64_FIRST  = 8'h0e;
  localparam logic [7:0] HDR_W64_SECOND = 8'h55;

  localparam logic [6:0] WIDTH_W24 = 7'd24;
  localparam logic [6:0] WIDTH_W47 = 7'd47;
  localparam logic [6:0] WIDTH_W64 = 7'd64;

  // Byte positions within a packet
  localparam logic [2:0] POS_ID_HI   = 3'd0;
  localparam logic [2:0] POS_ID_LO   = 3'd1;
  localparam logic [2:0] POS_SUB_HI  = 3'd2;
  localparam logic [2:0] POS_SUB_LO  = 3'd3;
  localparam logic [2:0] POS_HDR_1ST = 3'd4;
  localparam logic [2:0] POS_HDR_2ND = 3'd5;
  localparam logic [2:0] POS_DATA    = 3'd6;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] entry_value;
    logic [1:0]  packet_type;
    logic [15:0] dest_id;
    logic [15:0] dest_sub_id;
    logic        run_end;
  } out_word_t;

  function automatic logic [6:0] width_of_type(input logic [1:0] t);
    logic [6:0] w;
    case (t)
      TYPE_W24: w = WIDTH_W24;
      TYPE_W47: w = WIDTH_W47;
      default:  w = WIDTH_W64;
    endcase
    return w;
  endfunction

endpackage

### design/bit_packed_entry_deframer.sv
// Deframer for bit-packed entries. Takes one packet byte per word, with
// end_of_packet on the final byte, and returns entry words (24, 47 or 64
// bits wide, as the header selects) followed by one status word per packet.
// A byte is taken every cycle while results flow one per cycle; a byte that
// both completes an entry and ends the packet yields two result words, and
// the next byte waits while the two-word result buffer drains. The first
// result of a byte appears on out_data the cycle after it is accepted.
module bit_packed_entry_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bped_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bped_pkg::out_word_t out_data
);
  import bped_pkg::*;

  out_word_t  res0, res1;
  logic [1:0] res_count;
  logic       accept;
  logic       pop;

  out_word_t  slot0_r, slot1_r;
  logic [1:0] count_r;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;
  // room for up to two results once the head word leaves
  assign in_ready  = (count_r == 2'd0) || (count_r == 2'd1 && out_ready);
  assign accept    = in_valid && in_ready;

  bped_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_data),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (accept) begin
      count_r <= res_count;
    end else if (pop) begin
      count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0_r <= res0;
      slot1_r <= res1;
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

### design/bped_unpack.sv
module bped_unpack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  bped_pkg::in_word_t  in_word,
  output bped_pkg::out_word_t res0,
  output bped_pkg::out_word_t res1,
  output logic [1:0]          res_count
);
  import bped_pkg::*;

  logic [2:0]  byte_index_r, byte_index_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] sub_id_r, sub_id_nxt;
  logic [7:0]  header_first_r, header_first_nxt;
  logic [1:0]  type_r, type_nxt;
  logic        header_bad_r, header_bad_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  bits_left_r, bits_left_nxt;

  logic [7:0]  b;
  logic [63:0] b64;
  logic [6:0]  w;
  logic [6:0]  bl_less;
  logic [3:0]  extra;
  logic [6:0]  bl_after;
  logic [7:0]  b_low;
  logic        have_entry;
  out_word_t   entry_res, status_res;

  assign b   = in_word.byte_value;
  assign b64 = {56'd0, b};
  assign w   = width_of_type(type_r);

  always_comb begin
    byte_index_nxt   = byte_index_r;
    id_nxt           = id_r;
    sub_id_nxt       = sub_id_r;
    header_first_nxt = header_first_r;
    type_nxt         = type_r;
    header_bad_nxt   = header_bad_r;
    acc_nxt          = acc_r;
    bits_left_nxt    = bits_left_r;
    have_entry       = 1'b0;
    bl_less          = bits_left_r - 7'd8;
    extra            = 4'd8 - {1'b0, bits_left_r[2:0]};
    bl_after         = w - {3'd0, extra};
    b_low            = b & (8'hff >> bits_left_r[2:0]);
    entry_res        = '0;
    status_res       = '0;
    res0             = '0;
    res1             = '0;
    res_count        = 2'd0;

    if (accept) begin
      case (byte_index_r)
        POS_ID_HI:   id_nxt = {b, 8'd0};
        POS_ID_LO:   id_nxt = {id_r[15:8], b};
        POS_SUB_HI:  sub_id_nxt = {b, 8'd0};
        POS_SUB_LO:  sub_id_nxt = {sub_id_r[15:8], b};
        POS_HDR_1ST: header_first_nxt = b;
        POS_HDR_2ND: begin
          header_bad_nxt = 1'b0;
          if (header_first_r == HDR_W24_FIRST && b == HDR_W24_SECOND) begin
            type_nxt = TYPE_W24;
          end else if (header_first_r == HDR_W47_FIRST && b == HDR_W47_SECOND) begin
            type_nxt = TYPE_W47;
          end else if (header_first_r == HDR_W64_FIRST && b == HDR_W64_SECOND) begin
            type_nxt = TYPE_W64;
          end else begin
            type_nxt       = TYPE_W24;
            header_bad_nxt = 1'b1;
          end
          acc_nxt       = '0;
          bits_left_nxt = width_of_type(type_nxt);
        end
        default: begin
          if (!header_bad_r) begin
            if (bits_left_r >= 7'd8) begin
              bits_left_nxt = bl_less;
              acc_nxt       = acc_r | (b64 << bl_less);
              if (bl_less == 7'd0) begin
                have_entry            = 1'b1;
                entry_res.entry_value = acc_nxt;
                acc_nxt               = '0;
                bits_left_nxt         = w;
              end
            end else begin
              // byte straddles two entries: high bits close this one
              have_entry            = 1'b1;
              entry_res.entry_value = acc_r | (b64 >> extra);
              bits_left_nxt         = bl_after;
              acc_nxt               = {56'd0, b_low} << bl_after;
            end
          end
        end
      endcase

      entry_res.result_kind = KIND_ENTRY;
      entry_res.packet_type = type_r;
      entry_res.dest_id     = id_r;
      entry_res.dest_sub_id = sub_id_r;
      entry_res.run_end     = !in_word.end_of_packet;

      if (byte_index_r < POS_DATA) begin
        byte_index_nxt = byte_index_r + 3'd1;
      end

      status_res.run_end = 1'b1;
      if (byte_index_r < POS_DATA) begin
        status_res.result_kind = KIND_SHORT;
      end else if (header_bad_nxt) begin
        status_res.result_kind = KIND_BAD_HEADER;
        status_res.dest_id     = id_nxt;
        status_res.dest_sub_id = sub_id_nxt;
      end else begin
        status_res.result_kind = KIND_OK;
        status_res.packet_type = type_nxt;
        status_res.dest_id     = id_nxt;
        status_res.dest_sub_id = sub_id_nxt;
      end

      if (have_entry) begin
        res0      = entry_res;
        res1      = status_res;
        res_count = in_word.end_of_packet ? 2'd2 : 2'd1;
      end else begin
        res0      = status_res;
        res_count = in_word.end_of_packet ? 2'd1 : 2'd0;
      end

      if (in_word.end_of_packet) begin
        byte_index_nxt = POS_ID_HI;
        header_bad_nxt = 1'b0;
        acc_nxt        = '0;
        bits_left_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r   <= '0;
      id_r           <= '0;
      sub_id_r       <= '0;
      header_first_r <= '0;
      type_r         <= '0;
      header_bad_r   <= 1'b0;
      acc_r          <= '0;
      bits_left_r    <= '0;
    end else begin
      byte_index_r   <= byte_index_nxt;
      id_r           <= id_nxt;
      sub_id_r       <= sub_id_nxt;
      header_first_r <= header_first_nxt;
      type_r         <= type_nxt;
      header_bad_r   <= header_bad_nxt;
      acc_r          <= acc_nxt;
      bits_left_r    <= bits_left_nxt;
    end
  end

endmodule

### design/bped_checker.sv
module bped_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input bped_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bped_pkg::out_word_t out_data
);
  import bped_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != KIND_ENTRY |->
      out_data.entry_value == 64'd0 && out_data.run_end)
    else $error("status word with entry bits or without run_end");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_SHORT |->
      out_data.dest_id == 16'd0 && out_data.dest_sub_id == 16'd0 &&
      out_data.packet_type == TYPE_W24)
    else $error("too-short status carries ids");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind bit_packed_entry_deframer bped_checker u_bped_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
